>>> hdl/vsg_pkg.sv
// Shared constants, types and helpers of the speech segmenter.
// No dependencies; the top level uses it by scoped names.
package vsg_pkg;

  // regions one group may hold; the store keeps two groups
  localparam int MAX_GROUP_REGIONS = 16;
  localparam int SAMPLE_INDEX_BITS = 32;
  localparam int RES_MAX           = 64;

  localparam int SW    = SAMPLE_INDEX_BITS;
  localparam int FW    = 24;                           // frame counter width
  localparam int WINW  = 13;
  localparam int PW    = FW + WINW;                    // frame times window
  localparam int WW    = SW + 40;                      // scratch width for sample maths
  localparam int CNTW  = $clog2(MAX_GROUP_REGIONS + 1);
  localparam int IW    = $clog2(MAX_GROUP_REGIONS);
  localparam int AW    = $clog2(2 * MAX_GROUP_REGIONS);
  localparam int NW    = $clog2(RES_MAX + 1);
  localparam int RAW   = $clog2(RES_MAX);
  localparam int CFG_IDXW = 3;
  localparam int CFG_DW   = 32;

  localparam logic [FW-1:0] FRAME_MAX = {FW{1'b1}};
  localparam logic [SW-1:0] SMAX      = {SW{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDXW-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_WINDOW    = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_MIN_SIL   = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_MIN_SPE   = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_PAD       = 3'd4;
  localparam logic [CFG_IDXW-1:0] REG_MAX_CHUNK = 3'd5;

  // one buffered result
  typedef struct packed {
    logic [SW-1:0] rng_start;
    logic [SW-1:0] rng_end;
    logic          rv;
    logic          cl;
  } res_t;

  // sample index to the 32-bit output field
  function automatic logic [31:0] to_out(input logic [SW-1:0] v);
    logic [SW+31:0] t;
    t = {32'd0, v};
    return t[31:0];
  endfunction

endpackage

>>> hdl/vsg_in_if.sv
// Input channel of the speech segmenter: one window score per word.
// Depends on nothing.
interface vsg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] speech_prob;
  logic        is_final;
  logic [31:0] total_samples;

  modport source (output valid, speech_prob, is_final, total_samples, input ready);
  modport sink   (input valid, speech_prob, is_final, total_samples, output ready);
endinterface

>>> hdl/vsg_out_if.sv
// Output channel of the speech segmenter: one sample range per word.
// Depends on nothing.
interface vsg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic        range_valid;
  logic        chunk_last;
  logic        stream_done;
  logic        burst_last;
  logic        overflow;

  modport source (output valid, range_start, range_end, range_valid, chunk_last,
                  stream_done, burst_last, overflow, input ready);
  modport sink   (input valid, range_start, range_end, range_valid, chunk_last,
                  stream_done, burst_last, overflow, output ready);
endinterface

>>> hdl/vad_speech_segmenter.sv
// Top level of the speech segmenter.
// Depends on vsg_pkg, vsg_in_if and vsg_out_if.
//
// One window score is taken at a time. The block thresholds it, tracks the
// open speech region, and when a region closes writes it into the group
// store (a synchronous RAM with one write and one read port, in two banks:
// the held group and the group being filled). Emitting a group walks the
// store one region at a time: read, multiply by the window size, pad and
// clamp, then split into range pieces. Ranges go into a 64-word result RAM
// and are then sent one word at a time, each held until ready takes it.
// No clearing pass after reset.
module vad_speech_segmenter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vsg_pkg::CFG_IDXW-1:0]  cfg_index,
  input  logic [vsg_pkg::CFG_DW-1:0]    cfg_wdata,
  vsg_in_if.sink                        speech_in,
  vsg_out_if.source                     range_out
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SUBMIT   = 4'd1;
  localparam logic [3:0] ST_SWAP     = 4'd2;
  localparam logic [3:0] ST_FINCHK   = 4'd3;
  localparam logic [3:0] ST_CLEAR    = 4'd4;
  localparam logic [3:0] ST_FLUSH    = 4'd5;
  localparam logic [3:0] ST_EM_NEXT  = 4'd6;
  localparam logic [3:0] ST_EM_RD    = 4'd7;
  localparam logic [3:0] ST_EM_PAD   = 4'd8;
  localparam logic [3:0] ST_EM_SPLIT = 4'd9;
  localparam logic [3:0] ST_EM_END   = 4'd10;
  localparam logic [3:0] ST_OREAD    = 4'd11;
  localparam logic [3:0] ST_ORD      = 4'd12;
  localparam logic [3:0] ST_OSEND    = 4'd13;

  // configuration
  logic [15:0] thr, msil, mspe;
  logic [12:0] win;
  logic [23:0] pad;
  logic [31:0] cap;

  // stream state
  logic [3:0]                  state, ret;
  logic [vsg_pkg::FW-1:0]      win_idx, first, stop, silence, speech;
  logic                        open;
  logic [vsg_pkg::CNTW-1:0]    ocnt, hcnt, k;
  logic                        sel, fin_r, seg, w_held, w_open, pend, ovf;
  logic [31:0]                 total_r, plen;
  logic [vsg_pkg::NW-1:0]      n;
  logic [vsg_pkg::RAW-1:0]     oi;
  logic [vsg_pkg::PW-1:0]      smul, emul;
  logic [vsg_pkg::SW-1:0]      s_r, e_r;
  vsg_pkg::res_t               lastres;

  // memories
  logic [47:0]                 gstore [2*vsg_pkg::MAX_GROUP_REGIONS];
  logic [47:0]                 g_rdata;
  vsg_pkg::res_t               rmem [vsg_pkg::RES_MAX];
  vsg_pkg::res_t               r_rdata;

  // effective registers, zero acting as one
  logic [12:0] win_e;
  logic [15:0] msil_e, mspe_e;
  logic [31:0] cap_e;
  always_comb begin
    win_e  = (win  == '0) ? 13'd1 : win;
    msil_e = (msil == '0) ? 16'd1 : msil;
    mspe_e = (mspe == '0) ? 16'd1 : mspe;
    cap_e  = (cap  == '0) ? 32'd1 : cap;
  end

  // window classification and region tracking at accept
  logic                   acc, is_sp, o1, sub1;
  logic [vsg_pkg::FW-1:0] w_inc, f1, s1, sr1, srp;
  always_comb begin
    acc   = speech_in.valid && speech_in.ready;
    is_sp = speech_in.speech_prob >= thr;
    w_inc = (win_idx == vsg_pkg::FRAME_MAX) ? win_idx : win_idx + 1'b1;
    srp   = (silence == vsg_pkg::FRAME_MAX) ? silence : silence + 1'b1;
    f1 = first; s1 = stop; sr1 = silence; o1 = open; sub1 = 1'b0;
    if (is_sp) begin
      o1 = 1'b1;
      f1 = open ? first : win_idx;
      s1 = w_inc;
      sr1 = '0;
    end else if (open) begin
      if (srp >= vsg_pkg::FW'(msil_e)) begin
        o1 = 1'b0; sr1 = '0; sub1 = 1'b1;
      end else begin
        sr1 = srp;
      end
    end
  end

  // group submission
  logic [vsg_pkg::FW-1:0]   sp_len;
  logic [vsg_pkg::FW:0]     sp_sum;
  logic [vsg_pkg::FW-1:0]   speech_new;
  logic [vsg_pkg::CNTW-1:0] ocnt_new;
  always_comb begin
    sp_len     = (stop > first) ? stop - first : '0;
    sp_sum     = {1'b0, speech} + {1'b0, sp_len};
    speech_new = sp_sum[vsg_pkg::FW] ? vsg_pkg::FRAME_MAX : sp_sum[vsg_pkg::FW-1:0];
    ocnt_new   = ocnt + 1'b1;
  end

  // store addressing: bank sel holds the complete group
  logic [vsg_pkg::CNTW-1:0] seg_cnt;
  logic [vsg_pkg::IW-1:0]   k_idx, o_idx;
  logic [vsg_pkg::AW-1:0]   st_raddr, st_waddr;
  logic                     st_we;
  logic                     rbank;
  always_comb begin
    seg_cnt  = seg ? (w_open ? ocnt : '0) : (w_held ? hcnt : '0);
    k_idx    = k[vsg_pkg::IW-1:0];
    o_idx    = ocnt[vsg_pkg::IW-1:0];
    rbank    = seg ? ~sel : sel;
    st_raddr = rbank ? vsg_pkg::AW'(vsg_pkg::MAX_GROUP_REGIONS) + vsg_pkg::AW'(k_idx)
                     : vsg_pkg::AW'(k_idx);
    st_waddr = (~sel) ? vsg_pkg::AW'(vsg_pkg::MAX_GROUP_REGIONS) + vsg_pkg::AW'(o_idx)
                      : vsg_pkg::AW'(o_idx);
    st_we    = (state == ST_SUBMIT) &&
               (ocnt < vsg_pkg::CNTW'(vsg_pkg::MAX_GROUP_REGIONS));
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      gstore[st_waddr] <= {first, stop};
    end
    g_rdata <= gstore[st_raddr];
  end

  // pad, saturate and clamp one region
  logic [vsg_pkg::WW-1:0] ts, te, s0, e0, s1w, e1w;
  always_comb begin
    ts  = vsg_pkg::WW'(smul);
    te  = vsg_pkg::WW'(emul);
    s0  = (ts > vsg_pkg::WW'(vsg_pkg::SMAX)) ? vsg_pkg::WW'(vsg_pkg::SMAX) : ts;
    e0  = (te > vsg_pkg::WW'(vsg_pkg::SMAX)) ? vsg_pkg::WW'(vsg_pkg::SMAX) : te;
    s1w = (s0 > vsg_pkg::WW'(pad)) ? s0 - vsg_pkg::WW'(pad) : '0;
    e1w = e0 + vsg_pkg::WW'(pad);
    if (e1w > vsg_pkg::WW'(vsg_pkg::SMAX)) e1w = vsg_pkg::WW'(vsg_pkg::SMAX);
    if (fin_r && (e1w > vsg_pkg::WW'(total_r))) e1w = vsg_pkg::WW'(total_r);
    if (e1w < s1w) e1w = s1w;
  end

  // split and pack one piece
  logic [vsg_pkg::WW-1:0] diff, s_cap;
  logic                   long_rg, close, full;
  vsg_pkg::res_t          prev_w, new_res;
  always_comb begin
    diff    = vsg_pkg::WW'(e_r) - vsg_pkg::WW'(s_r);
    s_cap   = vsg_pkg::WW'(s_r) + vsg_pkg::WW'(cap_e);
    long_rg = diff > vsg_pkg::WW'(cap_e);
    close   = pend && (long_rg || (vsg_pkg::WW'(plen) + diff > vsg_pkg::WW'(cap_e)));
    full    = n >= vsg_pkg::NW'(vsg_pkg::RES_MAX);
    prev_w  = lastres;
    prev_w.cl = lastres.cl | close;
    new_res.rng_start = s_r;
    new_res.rng_end   = long_rg ? s_cap[vsg_pkg::SW-1:0] : e_r;
    new_res.rv        = 1'b1;
    new_res.cl        = long_rg;
  end

  // result RAM
  logic [vsg_pkg::NW-1:0]  nm1;
  logic [vsg_pkg::RAW-1:0] r_waddr;
  logic                    r_we;
  vsg_pkg::res_t           r_wdata;
  always_comb begin
    nm1     = n - 1'b1;
    r_waddr = nm1[vsg_pkg::RAW-1:0];
    r_we    = 1'b0;
    r_wdata = lastres;
    if (state == ST_EM_SPLIT && !full && n != '0) begin
      r_we = 1'b1; r_wdata = prev_w;
    end else if (state == ST_FLUSH && n != '0) begin
      r_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    r_rdata <= rmem[oi];
  end

  logic o_last;
  assign o_last = (n == '0) || ({1'b0, oi} + 1'b1 == n);

  assign speech_in.ready = (state == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd32768; win <= 13'd512; msil <= 16'd1; mspe <= 16'd1;
      pad <= '0; cap <= 32'd480000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsg_pkg::REG_THRESHOLD: thr  <= cfg_wdata[15:0];
        vsg_pkg::REG_WINDOW:    win  <= cfg_wdata[12:0];
        vsg_pkg::REG_MIN_SIL:   msil <= cfg_wdata[15:0];
        vsg_pkg::REG_MIN_SPE:   mspe <= cfg_wdata[15:0];
        vsg_pkg::REG_PAD:       pad  <= cfg_wdata[23:0];
        vsg_pkg::REG_MAX_CHUNK: cap  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; ret <= ST_IDLE;
      win_idx <= '0; first <= '0; stop <= '0; silence <= '0; speech <= '0;
      open <= 1'b0; ocnt <= '0; hcnt <= '0; k <= '0; sel <= 1'b0;
      fin_r <= 1'b0; seg <= 1'b0; w_held <= 1'b0; w_open <= 1'b0;
      pend <= 1'b0; ovf <= 1'b0; plen <= '0; n <= '0; oi <= '0;
      range_out.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            win_idx <= w_inc;
            first   <= f1;
            stop    <= s1;
            silence <= sr1;
            open    <= o1 & ~speech_in.is_final;
            fin_r   <= speech_in.is_final;
            total_r <= speech_in.total_samples;
            n       <= '0;
            ovf     <= 1'b0;
            state   <= (sub1 | (o1 & speech_in.is_final)) ? ST_SUBMIT : ST_FINCHK;
          end
        end
        ST_SUBMIT: begin
          if (!st_we) begin
            ovf   <= 1'b1;
            state <= ST_FINCHK;
          end else begin
            ocnt <= ocnt_new;
            if (speech_new >= vsg_pkg::FW'(mspe_e)) begin
              if (hcnt != '0) begin
                seg <= 1'b0; k <= '0; pend <= 1'b0; plen <= '0;
                w_held <= 1'b1; w_open <= 1'b0; ret <= ST_SWAP;
                state <= ST_EM_NEXT;
              end else begin
                state <= ST_SWAP;
              end
            end else begin
              speech <= speech_new;
              state  <= ST_FINCHK;
            end
          end
        end
        ST_SWAP: begin
          sel <= ~sel; hcnt <= ocnt; ocnt <= '0; speech <= '0;
          state <= ST_FINCHK;
        end
        ST_FINCHK: begin
          if (fin_r) begin
            seg <= 1'b0; k <= '0; pend <= 1'b0; plen <= '0;
            w_held <= 1'b1; w_open <= 1'b1; ret <= ST_CLEAR;
            state <= ST_EM_NEXT;
          end else begin
            state <= ST_FLUSH;
          end
        end
        ST_CLEAR: begin
          win_idx <= '0; first <= '0; stop <= '0; silence <= '0; speech <= '0;
          open <= 1'b0; ocnt <= '0; hcnt <= '0;
          state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          oi <= '0;
          if (n == '0 && !(fin_r || ovf)) state <= ST_IDLE;
          else                            state <= ST_OREAD;
        end
        ST_EM_NEXT: begin
          if (k < seg_cnt) begin
            state <= ST_EM_RD;
          end else if (!seg) begin
            seg <= 1'b1; k <= '0;
          end else begin
            state <= ST_EM_END;
          end
        end
        ST_EM_RD: begin
          smul  <= g_rdata[47:24] * win_e;
          emul  <= g_rdata[23:0] * win_e;
          state <= ST_EM_PAD;
        end
        ST_EM_PAD: begin
          s_r   <= s1w[vsg_pkg::SW-1:0];
          e_r   <= e1w[vsg_pkg::SW-1:0];
          state <= ST_EM_SPLIT;
        end
        ST_EM_SPLIT: begin
          if (full) begin
            // result limit: drop the rest of this emission
            ovf <= 1'b1;
            if (close) lastres.cl <= 1'b1;
            state <= ret;
          end else begin
            lastres <= new_res;
            n <= n + 1'b1;
            if (long_rg) begin
              s_r <= s_cap[vsg_pkg::SW-1:0];
              pend <= 1'b0; plen <= '0;
            end else begin
              pend <= 1'b1;
              plen <= (close ? 32'd0 : plen) + diff[31:0];
              k <= k + 1'b1;
              state <= ST_EM_NEXT;
            end
          end
        end
        ST_EM_END: begin
          if (pend) lastres.cl <= 1'b1;
          state <= ret;
        end
        ST_OREAD: begin
          state <= ST_ORD;
        end
        ST_ORD: begin
          if (n == '0) begin
            range_out.range_start <= '0;
            range_out.range_end   <= '0;
            range_out.range_valid <= 1'b0;
            range_out.chunk_last  <= 1'b0;
          end else begin
            range_out.range_start <= vsg_pkg::to_out(r_rdata.rng_start);
            range_out.range_end   <= vsg_pkg::to_out(r_rdata.rng_end);
            range_out.range_valid <= r_rdata.rv;
            range_out.chunk_last  <= r_rdata.cl;
          end
          range_out.burst_last  <= o_last;
          range_out.stream_done <= o_last & fin_r;
          range_out.overflow    <= ovf;
          range_out.valid       <= 1'b1;
          state <= ST_OSEND;
        end
        ST_OSEND: begin
          if (range_out.ready) begin
            range_out.valid <= 1'b0;
            if (o_last) begin
              state <= ST_IDLE;
            end else begin
              oi <= oi + 1'b1;
              state <= ST_OREAD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/vsg_checker.sv
// Port-level checks of the speech segmenter, bound to its top level.
// Depends on vad_speech_segmenter's ports only.
module vsg_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic range_valid,
  input logic chunk_last,
  input logic stream_done,
  input logic burst_last
);

  // a word on offer stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn");

  // one item at a time: no input while a result is out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while results pending");

  // end of stream closes the burst
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> burst_last)
    else $error("stream_done before burst end");

  // a bare notice stands alone and ends no chunk
  a_bare: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_valid |-> burst_last && !chunk_last)
    else $error("malformed bare notice");

endmodule

bind vad_speech_segmenter vsg_checker u_vsg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (speech_in.ready),
  .out_valid   (range_out.valid),
  .out_ready   (range_out.ready),
  .range_valid (range_out.range_valid),
  .chunk_last  (range_out.chunk_last),
  .stream_done (range_out.stream_done),
  .burst_last  (range_out.burst_last)
);
